FILE: rtl/core/dahr_pkg.sv
// ----------------------------------------------------------------------------
// dahr_pkg
// Shared widths, fixed-point constants and the exp2 root table for the
// envelope ducking gain core.
// ----------------------------------------------------------------------------
package dahr_pkg;

	localparam int COUNT_W      = 20;                   // stage lengths and counter
	localparam int FRAC_W       = 16;                   // level fraction bits
	localparam int LEVEL_W      = FRAC_W + 1;           // Q1.16 level
	localparam int SMOOTH_EXTRA = 7;
	localparam int SMOOTH_W     = LEVEL_W + SMOOTH_EXTRA;
	localparam int DIV_NUM_W    = COUNT_W + FRAC_W;     // count << FRAC_W
	localparam int DIV_CNT_W    = $clog2(DIV_NUM_W + 1);
	localparam int MUL_W        = 32;
	localparam int Q_W          = 30;                   // Q0.30 working format
	localparam int ROOT_N       = 16;
	localparam int EXP_W        = 12;
	localparam int COEFF_W      = 16;

	localparam logic [LEVEL_W-1:0]  ONE        = {1'b1, {FRAC_W{1'b0}}};
	localparam logic [SMOOTH_W-1:0] SMOOTH_MAX = {ONE, {SMOOTH_EXTRA{1'b0}}};
	localparam logic [EXP_W-1:0]    EXP_MIN    = 12'd26;
	localparam logic [EXP_W-1:0]    EXP_MAX    = 12'd2560;
	localparam logic [COEFF_W-1:0]  COEFF_MAX  = 16'd65208;

	typedef logic [ROOT_N-1:0][Q_W-1:0] root_tab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > v) b = b >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// entry k holds 2^(-2^-(k+1)) in Q0.30, each the floored root of the one before
	function automatic root_tab_t exp_roots();
		root_tab_t   tab;
		logic [63:0] r;
		r = 64'd1 << (Q_W - 1);
		for (int k = 0; k < ROOT_N; k++) begin
			r = isqrt64(r << Q_W);
			tab[k] = r[Q_W-1:0];
		end
		return tab;
	endfunction

	localparam root_tab_t EXP_ROOT = exp_roots();

endpackage

FILE: rtl/core/dahr_mul.sv
// ----------------------------------------------------------------------------
// dahr_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module dahr_mul import dahr_pkg::*; (
	input  logic                 clk,
	input  logic [MUL_W-1:0]     a,
	input  logic [MUL_W-1:0]     b,
	output logic [2*MUL_W-1:0]   p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

FILE: rtl/core/dahr_div.sv
// ----------------------------------------------------------------------------
// dahr_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dahr_div import dahr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIV_NUM_W-1:0]  num,
	input  logic [COUNT_W-1:0]    den,
	output logic                  done,
	output logic [DIV_NUM_W-1:0]  quot
);

	logic [COUNT_W-1:0]   rem_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [COUNT_W-1:0]   den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [COUNT_W:0]     rem_sh;
	logic                 ge;
	logic [COUNT_W:0]     rem_nx;

	always_comb begin
		rem_sh = {rem_q, quo_q[DIV_NUM_W-1]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_nx[COUNT_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

FILE: rtl/core/dahr_envelope_ducking_gain_core.sv
// ----------------------------------------------------------------------------
// dahr_envelope_ducking_gain_core
// Delay/attack/hold/release envelope with curved ramps, one-pole smoothing
// and ducking gain output, one sample tick per transfer.
// ----------------------------------------------------------------------------
// Each input transfer is one sample tick carrying a trigger bit; each tick
// gives exactly one gain transfer (Q1.16, 0..1.0). The core works on one tick
// at a time and drops s_tready until the result sits in the output register,
// so a new tick can be taken while the last gain still waits for m_tready.
// Ticks in idle, delay or hold skip the divide and the power steps. Attack
// and release ticks run the bit-serial divide for ramp progress, then 16
// squarings for the log2 and 16 products for the exp2 on the single shared
// 32x32 multiplier, plus the ramp, smoother and gain products on the same
// multiplier. A ramp point at zero or full progress skips the power steps.
// A stalled output register adds its wait.
// No clearing pass after reset.
// Configuration registers are written through cfg_we/cfg_addr/cfg_wdata
// while the core is idle, a rule for the user that the core does not enforce;
// out-of-range exponent, coefficient and depth are clamped when used.
// ----------------------------------------------------------------------------
module dahr_envelope_ducking_gain_core import dahr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,    // [0] trigger, [7:1] zero
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [23:0]        m_tdata,    // [16:0] gain_out, [23:17] zero
	input  logic               cfg_we,
	input  logic [2:0]         cfg_addr,
	input  logic [COUNT_W-1:0] cfg_wdata
);

	typedef enum logic [2:0] {
		REG_DELAY, REG_ATTACK, REG_HOLD, REG_RELEASE, REG_CURVE, REG_COEFF, REG_DEPTH
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DELAY, ST_ATTACK, ST_HOLD, ST_RELEASE
	} stage_t;

	typedef enum logic [3:0] {
		S_IDLE, S_TICK, S_DIV, S_LOG_MUL, S_LOG_UPD, S_EXP_T, S_EXP_SET,
		S_EXP_MUL, S_EXP_UPD, S_EXP_FIN, S_APPLY, S_VAL, S_SM_MUL, S_SM_UPD,
		S_GAIN_MUL, S_OUT
	} seq_t;

	typedef struct packed {
		stage_t              stage;
		logic                rel_we;
		logic [LEVEL_W-1:0]  rel_org;
	} chain_t;

	// stage entry chain: skipped stages fall straight through to the next
	function automatic chain_t enter_stage(
		input stage_t             start,
		input logic [LEVEL_W-1:0] tgt,
		input logic [COUNT_W-1:0] atk_len,
		input logic [COUNT_W-1:0] hld_len,
		input logic [COUNT_W-1:0] rls_len
	);
		chain_t             c;
		stage_t             st;
		logic [LEVEL_W-1:0] t;
		st = start;
		t  = tgt;
		if (st == ST_ATTACK && atk_len <= COUNT_W'(1)) st = ST_HOLD;
		if (st == ST_HOLD) begin
			t = ONE;
			if (hld_len == '0) st = ST_RELEASE;
		end
		c.rel_we  = 1'b0;
		c.rel_org = (t > ONE) ? ONE : t;
		if (st == ST_RELEASE) begin
			c.rel_we = 1'b1;
			if (rls_len <= COUNT_W'(1)) st = ST_IDLE;
		end
		c.stage = st;
		return c;
	endfunction

	// configuration
	logic [COUNT_W-1:0]  delay_len_q, atk_len_q, hold_len_q, rel_len_q;
	logic [EXP_W-1:0]    curve_q;
	logic [COEFF_W-1:0]  coeff_q;
	logic [LEVEL_W-1:0]  depth_q;

	// envelope state
	seq_t                seq_q;
	stage_t              stage_q;
	logic [COUNT_W-1:0]  count_q;
	logic [LEVEL_W-1:0]  atk_org_q, rel_org_q, target_q;
	logic [SMOOTH_W-1:0] smooth_q;

	// power unit working registers
	logic [Q_W:0]        m_q;
	logic [FRAC_W-1:0]   frac_q;
	logic [4:0]          lg_int_q;
	logic [3:0]          step_q;
	logic [FRAC_W-1:0]   fp_q;
	logic [4:0]          ip_q;
	logic [Q_W:0]        y_q;
	logic [LEVEL_W-1:0]  sh_q;

	// output register
	logic                m_tvalid_q;
	logic [LEVEL_W-1:0]  m_tdata_q;

	// shared units
	logic [MUL_W-1:0]    mul_a, mul_b;
	logic [2*MUL_W-1:0]  mul_p;
	logic                div_start, div_done;
	logic [DIV_NUM_W-1:0] div_num, div_quot;
	logic [COUNT_W-1:0]  div_den;

	// combinational helpers
	logic                accept;
	logic                out_load;
	logic [COUNT_W:0]    cnt_inc;
	chain_t              ch_atk, ch_hold, ch_rel;
	logic [LEVEL_W-1:0]  prog, x_val;
	logic [3:0]          msb_idx;
	logic [COUNT_W-1:0]  exp_len;
	logic [EXP_W-1:0]    e_clamp;
	logic [COEFF_W-1:0]  c_clamp;
	logic [LEVEL_W-1:0]  k_smooth;
	logic [LEVEL_W-1:0]  depth_cl;
	logic [20:0]         log_val;
	logic [SMOOTH_W-1:0] t_ext, d_abs;
	logic                t_ge;
	logic [31:0]         sq;
	logic [24:0]         t_pow;
	logic [Q_W:0]        y_sh;
	logic [Q_W+1:0]      y_rnd;
	logic [17:0]         pow_res;
	logic [LEVEL_W:0]    atk_sum;
	logic [17:0]         drop;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (seq_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, m_tdata_q};
	// result moves into the output register once it is free or being drained
	assign out_load = (seq_q == S_OUT) && (!m_tvalid_q || m_tready);

	always_comb begin
		cnt_inc  = {1'b0, count_q} + 1'b1;
		ch_atk   = enter_stage(ST_ATTACK, target_q, atk_len_q, hold_len_q, rel_len_q);
		ch_hold  = enter_stage(ST_HOLD, target_q, atk_len_q, hold_len_q, rel_len_q);
		ch_rel   = enter_stage(ST_RELEASE, target_q, atk_len_q, hold_len_q, rel_len_q);

		exp_len  = (stage_q == ST_ATTACK) ? atk_len_q : rel_len_q;
		div_den  = (exp_len > COUNT_W'(1)) ? exp_len - 1'b1 : COUNT_W'(1);
		div_num  = {count_q, {FRAC_W{1'b0}}};
		div_start = (seq_q == S_TICK) &&
			(stage_q == ST_ATTACK || stage_q == ST_RELEASE);

		prog     = (div_quot > DIV_NUM_W'(ONE)) ? ONE : div_quot[LEVEL_W-1:0];
		x_val    = (stage_q == ST_ATTACK) ? prog : ONE - prog;
		msb_idx  = '0;
		for (int i = 0; i < FRAC_W; i++) begin
			if (x_val[i]) msb_idx = 4'(i);
		end

		e_clamp  = (curve_q < EXP_MIN) ? EXP_MIN : ((curve_q > EXP_MAX) ? EXP_MAX : curve_q);
		c_clamp  = (coeff_q > COEFF_MAX) ? COEFF_MAX : coeff_q;
		k_smooth = ONE - {1'b0, c_clamp};
		depth_cl = (depth_q > ONE) ? ONE : depth_q;

		log_val  = {lg_int_q, {FRAC_W{1'b0}}} - {5'b0, frac_q};
		sq       = mul_p[61:30];
		t_pow    = mul_p[32:8];

		y_sh     = y_q >> ip_q;
		y_rnd    = {1'b0, y_sh} + (32'd1 << (Q_W - 1 - FRAC_W));
		pow_res  = y_rnd[Q_W+1:Q_W-FRAC_W];

		t_ext    = {target_q, {SMOOTH_EXTRA{1'b0}}};
		t_ge     = t_ext >= smooth_q;
		d_abs    = t_ge ? t_ext - smooth_q : smooth_q - t_ext;

		atk_sum  = {1'b0, atk_org_q} + {1'b0, mul_p[32:16]};
		drop     = mul_p[40:23];
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (seq_q)
			S_LOG_MUL: begin
				mul_a = MUL_W'(m_q);
				mul_b = MUL_W'(m_q);
			end
			S_EXP_T: begin
				mul_a = MUL_W'(log_val);
				mul_b = MUL_W'(e_clamp);
			end
			S_EXP_MUL: begin
				mul_a = MUL_W'(y_q);
				mul_b = MUL_W'(EXP_ROOT[step_q]);
			end
			S_APPLY: begin
				if (stage_q == ST_ATTACK) begin
					mul_a = MUL_W'(sh_q);
					mul_b = MUL_W'(ONE - atk_org_q);
				end else begin
					mul_a = MUL_W'(rel_org_q);
					mul_b = MUL_W'(sh_q);
				end
			end
			S_SM_MUL: begin
				mul_a = MUL_W'(d_abs);
				mul_b = MUL_W'(k_smooth);
			end
			S_GAIN_MUL, S_OUT: begin
				mul_a = MUL_W'(smooth_q);
				mul_b = MUL_W'(ONE - depth_cl);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	dahr_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	dahr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_len_q <= '0;
			atk_len_q   <= COUNT_W'(1);
			hold_len_q  <= '0;
			rel_len_q   <= COUNT_W'(1);
			curve_q     <= EXP_W'(256);
			coeff_q     <= '0;
			depth_q     <= ONE;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_DELAY:   delay_len_q <= cfg_wdata;
				REG_ATTACK:  atk_len_q   <= cfg_wdata;
				REG_HOLD:    hold_len_q  <= cfg_wdata;
				REG_RELEASE: rel_len_q   <= cfg_wdata;
				REG_CURVE:   curve_q     <= cfg_wdata[EXP_W-1:0];
				REG_COEFF:   coeff_q     <= cfg_wdata[COEFF_W-1:0];
				REG_DEPTH:   depth_q     <= cfg_wdata[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and envelope state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q      <= S_IDLE;
			stage_q    <= ST_IDLE;
			count_q    <= '0;
			atk_org_q  <= '0;
			rel_org_q  <= ONE;
			target_q   <= '0;
			smooth_q   <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_q        <= '0;
			frac_q     <= '0;
			lg_int_q   <= '0;
			step_q     <= '0;
			fp_q       <= '0;
			ip_q       <= '0;
			y_q        <= '0;
			sh_q       <= '0;
		end else begin
			if (m_tvalid_q && m_tready && !out_load) m_tvalid_q <= 1'b0;

			unique case (seq_q)
				S_IDLE: begin
					if (accept) begin
						if (s_tdata[0]) begin
							// restart from the current smoothed level
							atk_org_q <= (smooth_q[SMOOTH_W-1:SMOOTH_EXTRA] > ONE) ?
								ONE : smooth_q[SMOOTH_W-1:SMOOTH_EXTRA];
							count_q   <= '0;
							if (delay_len_q != '0) begin
								stage_q <= ST_DELAY;
							end else begin
								stage_q <= ch_atk.stage;
								if (ch_atk.rel_we) rel_org_q <= ch_atk.rel_org;
							end
						end
						seq_q <= S_TICK;
					end
				end
				S_TICK: begin
					unique case (stage_q)
						ST_DELAY: begin
							target_q <= atk_org_q;
							if (cnt_inc >= {1'b0, delay_len_q}) begin
								count_q <= '0;
								stage_q <= ch_atk.stage;
								if (ch_atk.rel_we) rel_org_q <= ch_atk.rel_org;
							end else begin
								count_q <= cnt_inc[COUNT_W-1:0];
							end
							seq_q <= S_SM_MUL;
						end
						ST_HOLD: begin
							target_q <= ONE;
							if (cnt_inc >= {1'b0, hold_len_q}) begin
								count_q <= '0;
								stage_q <= ch_rel.stage;
								if (ch_rel.rel_we) rel_org_q <= ch_rel.rel_org;
							end else begin
								count_q <= cnt_inc[COUNT_W-1:0];
							end
							seq_q <= S_SM_MUL;
						end
						ST_ATTACK, ST_RELEASE: seq_q <= S_DIV;
						default: begin
							target_q <= '0;
							seq_q    <= S_SM_MUL;
						end
					endcase
				end
				S_DIV: begin
					if (div_done) begin
						if (x_val == '0) begin
							sh_q  <= '0;
							seq_q <= S_APPLY;
						end else if (x_val[FRAC_W]) begin
							sh_q  <= ONE;
							seq_q <= S_APPLY;
						end else begin
							// normalize mantissa to Q1.30
							m_q      <= (Q_W + 1)'(x_val[FRAC_W-1:0]) << (5'd30 - {1'b0, msb_idx});
							lg_int_q <= 5'd16 - {1'b0, msb_idx};
							frac_q   <= '0;
							step_q   <= '0;
							seq_q    <= S_LOG_MUL;
						end
					end
				end
				S_LOG_MUL: seq_q <= S_LOG_UPD;
				S_LOG_UPD: begin
					if (sq[31]) begin
						m_q    <= sq[31:1];
						frac_q <= {frac_q[FRAC_W-2:0], 1'b1};
					end else begin
						m_q    <= sq[30:0];
						frac_q <= {frac_q[FRAC_W-2:0], 1'b0};
					end
					step_q <= step_q + 1'b1;
					seq_q  <= (step_q == 4'd15) ? S_EXP_T : S_LOG_MUL;
				end
				S_EXP_T: seq_q <= S_EXP_SET;
				S_EXP_SET: begin
					fp_q   <= t_pow[FRAC_W-1:0];
					ip_q   <= t_pow[20:16];
					y_q    <= {1'b1, {Q_W{1'b0}}};
					step_q <= '0;
					if (t_pow[24:16] > 9'd30) begin
						sh_q  <= '0;
						seq_q <= S_APPLY;
					end else begin
						seq_q <= S_EXP_MUL;
					end
				end
				S_EXP_MUL: seq_q <= S_EXP_UPD;
				S_EXP_UPD: begin
					if (fp_q[4'd15 - step_q]) y_q <= mul_p[60:30];
					step_q <= step_q + 1'b1;
					seq_q  <= (step_q == 4'd15) ? S_EXP_FIN : S_EXP_MUL;
				end
				S_EXP_FIN: begin
					sh_q  <= (pow_res > 18'(ONE)) ? ONE : pow_res[LEVEL_W-1:0];
					seq_q <= S_APPLY;
				end
				S_APPLY: seq_q <= S_VAL;
				S_VAL: begin
					if (stage_q == ST_ATTACK) begin
						target_q <= atk_sum[LEVEL_W-1:0];
						if (cnt_inc >= {1'b0, atk_len_q}) begin
							count_q <= '0;
							stage_q <= ch_hold.stage;
							if (ch_hold.rel_we) rel_org_q <= ch_hold.rel_org;
						end else begin
							count_q <= cnt_inc[COUNT_W-1:0];
						end
					end else begin
						target_q <= mul_p[32:16];
						count_q  <= cnt_inc[COUNT_W-1:0];
						if (cnt_inc >= {1'b0, rel_len_q}) stage_q <= ST_IDLE;
					end
					seq_q <= S_SM_MUL;
				end
				S_SM_MUL: seq_q <= S_SM_UPD;
				S_SM_UPD: begin
					if (t_ge) smooth_q <= smooth_q + mul_p[39:16];
					else      smooth_q <= smooth_q - mul_p[39:16];
					seq_q <= S_GAIN_MUL;
				end
				S_GAIN_MUL: seq_q <= S_OUT;
				S_OUT: begin
					// wait for the output register to free up
					if (out_load) begin
						m_tdata_q  <= (drop >= 18'(ONE)) ? '0 : ONE - drop[LEVEL_W-1:0];
						m_tvalid_q <= 1'b1;
						seq_q      <= S_IDLE;
					end
				end
				default: seq_q <= S_IDLE;
			endcase
		end
	end

	a_smooth_range: assert property (@(posedge clk) disable iff (!arst_n)
		smooth_q <= SMOOTH_MAX) else $error("smoothed level above full scale");

	a_rel_range: assert property (@(posedge clk) disable iff (!arst_n)
		rel_org_q <= ONE) else $error("release origin above full scale");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> seq_q == S_DIV) else $error("divider finished outside divide step");

	a_accept_tick: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> seq_q == S_TICK) else $error("accepted tick did not start processing");

endmodule
